@@ design/bti_pkg.sv @@
`default_nettype none

package bti_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // one stored entry: four channel values over the time
  localparam int TIME_W  = 32;
  localparam int CHAN_W  = 16;
  localparam int VALS_W  = 4 * CHAN_W;
  localparam int ENTRY_W = VALS_W + TIME_W;

  // fraction and its divider step count
  localparam int QUO_W = 16;
  localparam int STEP_W = $clog2(QUO_W);

  // action codes
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // status codes
  localparam logic [2:0] STAT_ANSWERED = 3'd0;
  localparam logic [2:0] STAT_INSERTED = 3'd1;
  localparam logic [2:0] STAT_REPLACED = 3'd2;
  localparam logic [2:0] STAT_FULL     = 3'd3;
  localparam logic [2:0] STAT_EMPTY    = 3'd4;

  typedef struct packed {
    logic               action;
    logic signed [31:0] in_time;
    logic signed [15:0] in_steering;
    logic signed [15:0] in_throttle;
    logic signed [15:0] in_braking;
    logic signed [15:0] in_clutch;
  } bti_cmd_t;

  typedef struct packed {
    logic signed [15:0] out_steering;
    logic signed [15:0] out_throttle;
    logic signed [15:0] out_braking;
    logic signed [15:0] out_clutch;
    logic [2:0]         status;
  } bti_res_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_QFIRST,
    S_QFCMP,
    S_QLAST,
    S_QLCMP,
    S_SEARCH,
    S_SCMP,
    S_LCHK,
    S_LCMP,
    S_LINS,
    S_SHRD,
    S_SHWR,
    S_QRRD,
    S_QRCMP,
    S_QLRD,
    S_QLSET,
    S_DIV,
    S_MUL,
    S_ACC,
    S_EMIT
  } bti_state_t;

endpackage

`default_nettype wire

@@ design/bti_ram.sv @@
`default_nettype none

module bti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/breakpoint_table_linear_interpolator_core.sv @@
`default_nettype none

// Breakpoint table with piecewise linear interpolation over four channels.
// cmd channel (cmd_valid / cmd_stall / cmd) takes one word per item: a load
// inserts or replaces a breakpoint in time order, a query asks for the four
// channel values at a time. res channel (res_valid / res_stall / res) gives
// exactly one word per item, with a status code.
// Items are worked one at a time by a small sequencer around one table RAM
// (single read port, registered read) and one multiplier; cmd_stall is high
// from acceptance until the result is written into the output register.
// With n stored entries the binary search takes at most ceil(log2(n+1)) steps.
// A load then replaces an entry of equal time, is dropped on a full table, or
// inserts, moving the entries above it up one place to make room. A query
// clamps to the first or last entry outside the table range, returns an exact
// match as stored and otherwise interpolates (16 divider steps, 4 multiply/
// accumulate pairs); on an empty table it returns the empty status.
// The output register holds a result while res_stall is high; the next item
// is accepted meanwhile but its result waits for the register to free up.
// Synchronous reset empties the table (entry count to zero) and drops any
// pending result; table contents are not cleared.

module breakpoint_table_linear_interpolator_core
  import bti_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cmd_valid,
  output logic          cmd_stall,
  input  wire bti_cmd_t cmd,
  output logic          res_valid,
  input  wire logic     res_stall,
  output bti_res_t      res
);

  bti_state_t state, state_next;

  // item registers
  logic                     cur_action;
  logic signed [TIME_W-1:0] cur_time;
  logic [VALS_W-1:0]        cur_vals;

  // table occupancy and search bounds
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] lo;
  logic [CNT_W-1:0] hi;
  logic [IDX_W-1:0] mid;
  logic [IDX_W-1:0] idx;

  // interpolation working registers
  logic [TIME_W-1:0]        tr;
  logic [VALS_W-1:0]        vl;
  logic [VALS_W-1:0]        vr;
  logic [TIME_W-1:0]        rem;
  logic [TIME_W-1:0]        den;
  logic [QUO_W-1:0]         quot;
  logic [STEP_W-1:0]        step;
  logic [1:0]               ch;
  logic signed [2*CHAN_W+1:0] prod;

  // result being built
  logic [VALS_W-1:0] vals;
  logic [2:0]        stat;

  // RAM port
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  bti_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // read word split and time compares
  logic signed [TIME_W-1:0] rd_time;
  logic [VALS_W-1:0]        rd_vals;
  logic                     rd_lt;
  logic                     rd_eq;
  logic                     t_le;
  logic                     t_ge;

  assign rd_time = $signed(ram_rdata[TIME_W-1:0]);
  assign rd_vals = ram_rdata[ENTRY_W-1:TIME_W];
  assign rd_lt   = rd_time < cur_time;
  assign rd_eq   = rd_time == cur_time;
  assign t_le    = cur_time <= rd_time;
  assign t_ge    = cur_time >= rd_time;

  // search midpoint
  logic [CNT_W:0]   mid_sum;
  logic             search_open;
  logic [IDX_W-1:0] mid_now;

  assign mid_sum     = {1'b0, lo} + {1'b0, hi};
  assign mid_now     = mid_sum[IDX_W:1];
  assign search_open = lo < hi;

  // address helpers
  logic [CNT_W-1:0] count_m1;
  logic [CNT_W-1:0] lo_m1;
  logic [IDX_W-1:0] idx_m1;
  logic             shift_more;

  assign count_m1   = count - CNT_W'(1);
  assign lo_m1      = lo - CNT_W'(1);
  assign idx_m1     = idx - IDX_W'(1);
  assign shift_more = CNT_W'(idx) > lo;

  // divider step
  logic [TIME_W:0] rem2;
  logic [TIME_W:0] rem_sub;
  logic            rem_ge;

  assign rem2    = {rem, 1'b0};
  assign rem_sub = rem2 - {1'b0, den};
  assign rem_ge  = rem2 >= {1'b0, den};

  // channel multiply and accumulate
  logic signed [CHAN_W-1:0]   vl_c;
  logic signed [CHAN_W-1:0]   vr_c;
  logic signed [CHAN_W:0]     dv;
  logic signed [CHAN_W+1:0]   acc;

  assign vl_c = $signed(vl[CHAN_W*ch +: CHAN_W]);
  assign vr_c = $signed(vr[CHAN_W*ch +: CHAN_W]);
  assign dv   = $signed({vr_c[CHAN_W-1], vr_c}) - $signed({vl_c[CHAN_W-1], vl_c});
  assign acc  = $signed({{2{vl_c[CHAN_W-1]}}, vl_c}) + prod[2*CHAN_W+1:QUO_W];

  logic cmd_accept;
  logic res_free;

  assign cmd_accept = cmd_valid && !cmd_stall;
  assign res_free   = !res_valid || !res_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_accept) begin
          if (cmd.action == ACT_LOAD) begin
            state_next = S_SEARCH;
          end else if (count == '0) begin
            state_next = S_EMIT;
          end else begin
            state_next = S_QFIRST;
          end
        end
      end
      S_QFIRST: state_next = S_QFCMP;
      S_QFCMP:  state_next = t_le ? S_EMIT : S_QLAST;
      S_QLAST:  state_next = S_QLCMP;
      S_QLCMP:  state_next = t_ge ? S_EMIT : S_SEARCH;
      S_SEARCH: begin
        if (search_open) begin
          state_next = S_SCMP;
        end else if (cur_action == ACT_LOAD) begin
          state_next = S_LCHK;
        end else begin
          state_next = S_QRRD;
        end
      end
      S_SCMP:   state_next = S_SEARCH;
      S_LCHK:   state_next = (lo < count) ? S_LCMP : S_LINS;
      S_LCMP:   state_next = rd_eq ? S_EMIT : S_LINS;
      S_LINS:   state_next = (count == CNT_W'(TABLE_DEPTH)) ? S_EMIT : S_SHRD;
      S_SHRD:   state_next = shift_more ? S_SHWR : S_EMIT;
      S_SHWR:   state_next = S_SHRD;
      S_QRRD:   state_next = S_QRCMP;
      S_QRCMP:  state_next = rd_eq ? S_EMIT : S_QLRD;
      S_QLRD:   state_next = S_QLSET;
      S_QLSET:  state_next = S_DIV;
      S_DIV:    state_next = (step == STEP_W'(QUO_W - 1)) ? S_MUL : S_DIV;
      S_MUL:    state_next = S_ACC;
      S_ACC:    state_next = (ch == 2'd3) ? S_EMIT : S_MUL;
      S_EMIT:   state_next = res_free ? S_IDLE : S_EMIT;
      default:  state_next = S_IDLE;
    endcase
  end

  // RAM control and handshake outputs
  always_comb begin
    cmd_stall = state != S_IDLE;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = lo[IDX_W-1:0];
    ram_wdata = {cur_vals, cur_time};
    case (state)
      S_QLAST:  ram_raddr = count_m1[IDX_W-1:0];
      S_SEARCH: ram_raddr = mid_now;
      S_LCHK:   ram_raddr = lo[IDX_W-1:0];
      S_LCMP:   ram_we    = rd_eq;
      S_SHRD: begin
        ram_raddr = idx_m1;
        ram_we    = !shift_more;
      end
      S_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = ram_rdata;
      end
      S_QRRD:   ram_raddr = lo[IDX_W-1:0];
      S_QLRD:   ram_raddr = lo_m1[IDX_W-1:0];
      default:  ram_raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      // result taken; a new one loaded in the emit state takes its place
      if (res_valid && !res_stall && state != S_EMIT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_accept) begin
            cur_action <= cmd.action;
            cur_time   <= cmd.in_time;
            cur_vals   <= {cmd.in_clutch, cmd.in_braking, cmd.in_throttle,
                           cmd.in_steering};
            lo         <= '0;
            hi         <= count;
            vals       <= '0;
            stat       <= (cmd.action == ACT_QUERY && count == '0) ? STAT_EMPTY
                                                                    : STAT_ANSWERED;
          end
        end
        S_QFCMP: begin
          if (t_le) begin
            vals <= rd_vals;
          end
        end
        S_QLCMP: begin
          if (t_ge) begin
            vals <= rd_vals;
          end
        end
        S_SEARCH: mid <= mid_now;
        S_SCMP: begin
          if (rd_lt) begin
            lo <= CNT_W'(mid) + CNT_W'(1);
          end else begin
            hi <= CNT_W'(mid);
          end
        end
        S_LCMP: begin
          if (rd_eq) begin
            stat <= STAT_REPLACED;
          end
        end
        S_LINS: begin
          stat <= STAT_FULL;
          idx  <= count[IDX_W-1:0];
        end
        S_SHRD: begin
          if (!shift_more) begin
            count <= count + CNT_W'(1);
            stat  <= STAT_INSERTED;
          end
        end
        S_SHWR: idx <= idx_m1;
        S_QRCMP: begin
          tr <= ram_rdata[TIME_W-1:0];
          vr <= rd_vals;
          if (rd_eq) begin
            vals <= rd_vals;
          end
        end
        S_QLSET: begin
          vl   <= rd_vals;
          rem  <= cur_time - rd_time;
          den  <= tr - ram_rdata[TIME_W-1:0];
          quot <= '0;
          step <= '0;
        end
        // restoring division, one quotient bit a cycle
        S_DIV: begin
          rem  <= rem_ge ? rem_sub[TIME_W-1:0] : rem2[TIME_W-1:0];
          quot <= {quot[QUO_W-2:0], rem_ge};
          step <= step + STEP_W'(1);
          ch   <= '0;
        end
        S_MUL: prod <= $signed({1'b0, quot}) * dv;
        S_ACC: begin
          vals[CHAN_W*ch +: CHAN_W] <= acc[CHAN_W-1:0];
          ch <= ch + 2'd1;
        end
        S_EMIT: begin
          if (res_free) begin
            res_valid        <= 1'b1;
            res.out_steering <= vals[0*CHAN_W +: CHAN_W];
            res.out_throttle <= vals[1*CHAN_W +: CHAN_W];
            res.out_braking  <= vals[2*CHAN_W +: CHAN_W];
            res.out_clutch   <= vals[3*CHAN_W +: CHAN_W];
            res.status       <= stat;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire
